FILE: src/motor_ramp_autoreverse_controller_defines.svh
// Assertion macros used by the checker in src/mrac_checker.sv.
`ifndef MOTOR_RAMP_AUTOREVERSE_CONTROLLER_DEFINES_SVH
`define MOTOR_RAMP_AUTOREVERSE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MRAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MRAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mrac_pkg.sv
`default_nettype none

package mrac_pkg;

    localparam int KIND_W      = 3;
    localparam int SPEED_W     = 7;
    localparam int SPEED_IN_W  = 8;
    localparam int PERIOD_IN_W = 32;
    localparam int DUTY_W      = 8;
    localparam int STEP_W      = 7;
    localparam int PAUSE_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W    = 48;
    localparam int M_DATA_W    = 32;

    // Result beat layout
    localparam int OUT_A_LSB     = 0;
    localparam int OUT_B_LSB     = 8;
    localparam int OUT_SPEED_LSB = 16;
    localparam int OUT_DIR_LSB   = 23;
    localparam int OUT_MODE_LSB  = 24;
    localparam int OUT_HALT_LSB  = 26;

    localparam logic [SPEED_W-1:0] SPEED_MAX  = 7'd100;
    localparam logic [SPEED_W-1:0] SPEED_FULL = 7'd99;
    localparam logic [DUTY_W-1:0]  DUTY_FULL  = 8'd255;

    // x / 100 == (x * 5243) >> 19 for every x below 2**15
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [STEP_W-1:0]  RAMP_STEP_RST  = 7'd5;
    localparam logic [DUTY_W-1:0]  FLOOR_RST      = 8'd0;
    localparam logic [DUTY_W-1:0]  CEILING_RST    = 8'd255;
    localparam logic [PAUSE_W-1:0] PAUSE_RST      = 16'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 3'd0,
        KIND_START  = 3'd1,
        KIND_STOP   = 3'd2,
        KIND_DIR    = 3'd3,
        KIND_TOGGLE = 3'd4,
        KIND_SPEED  = 3'd5,
        KIND_PERIOD = 3'd6,
        KIND_BOTH   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        MODE_RAMP  = 2'd0,
        MODE_HOLD  = 2'd1,
        MODE_DOWN  = 2'd2,
        MODE_PAUSE = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAMP_STEP = 2'd0,
        CFG_FLOOR     = 2'd1,
        CFG_CEILING   = 2'd2,
        CFG_PAUSE     = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

FILE: src/motor_ramp_autoreverse_controller.sv
`default_nettype none

// Two-direction motor driver with soft speed ramp and timed auto-reverse. Every input beat
// (a control tick in s_tuser kind 0, or a command) yields exactly one result beat with the
// two PWM duties, present speed, applied direction, mode and halt flag. One beat is taken
// per clock while the output is not stalled. Each result passes through the first-stage
// registers and then the output registers before it is offered on m_tvalid. The first
// stage updates mode, speed, direction and timers and forms speed*(ceiling-floor); the
// second stage divides that product by 100 with a constant reciprocal multiply and loads
// the duty registers. The period is TIMER_BITS wide, the tick timer the wider of TIMER_BITS
// and PAUSE_W; the reverse period takes the low TIMER_BITS of its field. Write the
// configuration registers only while no beat is in flight.
module motor_ramp_autoreverse_controller #(
    parameter int TIMER_BITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // speed_percent[7:0], reverse_period_ticks[39:8], direction[40], emergency_stop[41]
    input  wire logic [mrac_pkg::S_DATA_W-1:0]     s_tdata,
    // kind[2:0]
    input  wire logic [mrac_pkg::KIND_W-1:0]       s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // drive_a[7:0], drive_b[15:8], speed_now[22:16], direction_now[23], mode_now[25:24],
    // halted[26]
    output logic [mrac_pkg::M_DATA_W-1:0]          m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mrac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mrac_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mrac_pkg::*;

    localparam int TL_BITS = (TIMER_BITS > PAUSE_W) ? TIMER_BITS : PAUSE_W;

    // configuration
    logic [STEP_W-1:0]  ramp_step_reg;
    logic [DUTY_W-1:0]  duty_floor_reg;
    logic [DUTY_W-1:0]  duty_ceiling_reg;
    logic [PAUSE_W-1:0] pause_ticks_reg;

    // controller state
    mode_t                 mode_reg, mode_next;
    logic [SPEED_W-1:0]    speed_reg, speed_next;
    logic [SPEED_W-1:0]    target_reg, target_next;
    logic                  dir_present_reg, dir_present_next;
    logic                  dir_wanted_reg, dir_wanted_next;
    logic                  running_reg, running_next;
    logic [TIMER_BITS-1:0] period_reg, period_next;
    logic [TL_BITS-1:0]    ticks_reg, ticks_next;

    // first stage
    logic                  s1_valid_reg;
    logic                  s1_drive_reg;
    logic [SPEED_W-1:0]    s1_speed_reg;
    logic                  s1_dir_reg;
    mode_t                 s1_mode_reg;
    logic                  s1_halted_reg;
    logic signed [16:0]    s1_prod_reg;
    logic [DUTY_W-1:0]     s1_floor_reg;

    // output stage; the duty fields double as the duty state
    logic                  m_valid_reg;
    logic [DUTY_W-1:0]     duty_a_reg, duty_a_next;
    logic [DUTY_W-1:0]     duty_b_reg, duty_b_next;
    logic [SPEED_W-1:0]    m_speed_reg;
    logic                  m_dir_reg;
    mode_t                 m_mode_reg;
    logic                  m_halted_reg;

    logic                  s_accept;
    logic                  s1_advance;

    // unpacked input beat
    kind_t                 in_kind;
    logic [SPEED_IN_W-1:0] in_speed;
    logic [TIMER_BITS-1:0] in_period;
    logic                  in_dir;
    logic                  in_estop;
    logic [SPEED_W-1:0]    in_target;

    logic                  drive;
    logic                  halted;
    logic signed [8:0]     span;
    logic signed [16:0]    prod;

    logic [15:0]           prod_mag;
    logic [28:0]           scaled;
    logic [9:0]            quot;
    logic [9:0]            level;
    logic [DUTY_W-1:0]     pwm;

    assign in_kind   = kind_t'(s_tuser);
    assign in_speed  = s_tdata[7:0];
    assign in_period = s_tdata[8 +: TIMER_BITS];
    assign in_dir    = s_tdata[40];
    assign in_estop  = s_tdata[41];

    assign in_target = in_speed[7] ? '0 :
                       (in_speed[6:0] > SPEED_MAX) ? SPEED_MAX : in_speed[6:0];

    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_step_reg    <= RAMP_STEP_RST;
            duty_floor_reg   <= FLOOR_RST;
            duty_ceiling_reg <= CEILING_RST;
            pause_ticks_reg  <= PAUSE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RAMP_STEP: ramp_step_reg    <= cfg_data[STEP_W-1:0];
                CFG_FLOOR:     duty_floor_reg   <= cfg_data[DUTY_W-1:0];
                CFG_CEILING:   duty_ceiling_reg <= cfg_data[DUTY_W-1:0];
                CFG_PAUSE:     pause_ticks_reg  <= cfg_data[PAUSE_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        logic [7:0] speed_up;
        logic [7:0] down_bound;
        mode_t      tick_mode;

        mode_next        = mode_reg;
        speed_next       = speed_reg;
        target_next      = target_reg;
        dir_present_next = dir_present_reg;
        dir_wanted_next  = dir_wanted_reg;
        running_next     = running_reg;
        period_next      = period_reg;
        ticks_next       = ticks_reg;
        drive            = 1'b0;
        tick_mode        = mode_reg;

        speed_up   = {1'b0, speed_reg} + {1'b0, ramp_step_reg};
        down_bound = {1'b0, target_reg} + {1'b0, ramp_step_reg};

        unique case (in_kind)
            KIND_TICK: begin
                if (ticks_reg != '0) begin
                    ticks_next = ticks_reg - TL_BITS'(1);
                end
                if (!running_reg && speed_reg != '0) begin
                    tick_mode = MODE_DOWN;
                end
                mode_next = tick_mode;
                if (running_reg || speed_reg != '0) begin
                    unique case (tick_mode)
                        MODE_RAMP: begin
                            if (speed_reg == target_reg) begin
                                mode_next  = MODE_HOLD;
                                ticks_next = TL_BITS'(period_reg);
                            end else begin
                                drive = 1'b1;
                                if (speed_reg < target_reg) begin
                                    speed_next = (speed_up > {1'b0, target_reg}) ?
                                                 target_reg : speed_up[SPEED_W-1:0];
                                end else if ({1'b0, speed_reg} < down_bound) begin
                                    speed_next = target_reg;
                                end else begin
                                    speed_next = speed_reg - ramp_step_reg;
                                end
                            end
                        end
                        MODE_HOLD: begin
                            // auto-reverse once the hold period runs out
                            if (period_reg != '0 && ticks_next == '0) begin
                                mode_next       = MODE_DOWN;
                                dir_wanted_next = !dir_wanted_reg;
                            end
                        end
                        MODE_DOWN: begin
                            drive = 1'b1;
                            if (speed_reg <= ramp_step_reg) begin
                                speed_next = '0;
                                ticks_next = TL_BITS'(pause_ticks_reg);
                                mode_next  = MODE_PAUSE;
                            end else begin
                                speed_next = speed_reg - ramp_step_reg;
                            end
                        end
                        MODE_PAUSE: begin
                            if (ticks_next == '0 && running_reg && !in_estop) begin
                                dir_present_next = dir_wanted_reg;
                                mode_next        = MODE_RAMP;
                            end
                        end
                        default: ;
                    endcase
                end
                // emergency on a driving tick: drop speed at once
                if (drive && in_estop) begin
                    speed_next = '0;
                    mode_next  = MODE_RAMP;
                end
            end
            KIND_START:  running_next    = 1'b1;
            KIND_STOP:   running_next    = 1'b0;
            KIND_DIR:    dir_wanted_next = in_dir;
            KIND_TOGGLE: dir_wanted_next = !dir_wanted_reg;
            KIND_SPEED:  target_next     = in_target;
            KIND_PERIOD: period_next     = in_period;
            KIND_BOTH: begin
                period_next = in_period;
                target_next = in_target;
            end
            default: ;
        endcase

        halted = !running_next || in_estop;

        if (in_kind != KIND_TICK) begin
            if (!halted) begin
                if (speed_reg == '0) begin
                    mode_next        = MODE_RAMP;
                    dir_present_next = dir_wanted_next;
                end else begin
                    mode_next = (dir_wanted_next == dir_present_reg) ? MODE_RAMP : MODE_DOWN;
                end
            end else begin
                mode_next = MODE_DOWN;
            end
        end

        span = $signed({1'b0, duty_ceiling_reg}) - $signed({1'b0, duty_floor_reg});
        prod = $signed({10'd0, speed_next}) * $signed({{8{span[8]}}, span});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_RAMP;
            speed_reg       <= '0;
            target_reg      <= '0;
            dir_present_reg <= 1'b0;
            dir_wanted_reg  <= 1'b0;
            running_reg     <= 1'b0;
            period_reg      <= '0;
            ticks_reg       <= '0;
        end else if (s_accept) begin
            mode_reg        <= mode_next;
            speed_reg       <= speed_next;
            target_reg      <= target_next;
            dir_present_reg <= dir_present_next;
            dir_wanted_reg  <= dir_wanted_next;
            running_reg     <= running_next;
            period_reg      <= period_next;
            ticks_reg       <= ticks_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_advance) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_drive_reg  <= drive;
            s1_speed_reg  <= speed_next;
            s1_dir_reg    <= dir_present_next;
            s1_mode_reg   <= mode_next;
            s1_halted_reg <= halted;
            s1_prod_reg   <= prod;
            s1_floor_reg  <= duty_floor_reg;
        end
    end

    // duty = floor + trunc(speed*(ceiling-floor)/100); 0 at speed 0, full at SPEED_FULL and up
    always_comb begin
        prod_mag = s1_prod_reg[16] ? 16'(-s1_prod_reg) : s1_prod_reg[15:0];
        scaled   = {13'd0, prod_mag} * {16'd0, RECIP_100};
        quot     = scaled[28:RECIP_SHIFT];
        level    = s1_prod_reg[16] ? ({2'b00, s1_floor_reg} - quot)
                                   : ({2'b00, s1_floor_reg} + quot);

        if (s1_speed_reg == '0) begin
            pwm = '0;
        end else if (s1_speed_reg >= SPEED_FULL) begin
            pwm = DUTY_FULL;
        end else begin
            pwm = level[DUTY_W-1:0];
        end

        duty_a_next = duty_a_reg;
        duty_b_next = duty_b_reg;
        if (s1_drive_reg) begin
            duty_a_next = s1_dir_reg ? pwm : '0;
            duty_b_next = s1_dir_reg ? '0 : pwm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            duty_a_reg  <= '0;
            duty_b_reg  <= '0;
        end else begin
            if (s1_advance) begin
                m_valid_reg <= 1'b1;
                duty_a_reg  <= duty_a_next;
                duty_b_reg  <= duty_b_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_speed_reg  <= s1_speed_reg;
            m_dir_reg    <= s1_dir_reg;
            m_mode_reg   <= s1_mode_reg;
            m_halted_reg <= s1_halted_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_halted_reg, m_mode_reg, m_dir_reg, m_speed_reg,
                       duty_b_reg, duty_a_reg};

endmodule

`default_nettype wire

FILE: src/mrac_checker.sv
`default_nettype none

`include "motor_ramp_autoreverse_controller_defines.svh"

module mrac_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [mrac_pkg::M_DATA_W-1:0]  m_tdata
);
    import mrac_pkg::*;

    logic [DUTY_W-1:0]  drive_a;
    logic [DUTY_W-1:0]  drive_b;
    logic [SPEED_W-1:0] speed_now;
    mode_t              mode_now;

    assign drive_a   = m_tdata[OUT_A_LSB +: DUTY_W];
    assign drive_b   = m_tdata[OUT_B_LSB +: DUTY_W];
    assign speed_now = m_tdata[OUT_SPEED_LSB +: SPEED_W];
    assign mode_now  = mode_t'(m_tdata[OUT_MODE_LSB +: 2]);

    // only one bridge side may be driven
    `MRAC_ASSERT_NOW(a_one_side, m_tvalid, drive_a == '0 || drive_b == '0, "both duties driven")

    `MRAC_ASSERT_NOW(a_speed_range, m_tvalid, speed_now <= SPEED_MAX, "speed above limit")

    // pause is only reached at standstill
    `MRAC_ASSERT_NOW(a_pause_still, m_tvalid && mode_now == MODE_PAUSE, speed_now == '0, "moving in pause")

    `MRAC_ASSERT_NEXT(a_hold_beat, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")

endmodule

bind motor_ramp_autoreverse_controller mrac_checker u_mrac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: dv/motor_drive_checker.sv
`default_nettype none

module motor_drive_checker import mrac_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    // speed_percent[7:0], reverse_period_ticks[39:8], direction[40], emergency_stop[41]
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // kind[2:0]
    input  wire logic [KIND_W-1:0]     s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    // drive_a[7:0], drive_b[15:8], speed_now[22:16], direction_now[23], mode_now[25:24],
    // halted[26]
    input  wire logic [M_DATA_W-1:0]   m_tdata,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         pending
);

    typedef struct packed {
        logic [DUTY_W-1:0]  duty_a;
        logic [DUTY_W-1:0]  duty_b;
        logic [SPEED_W-1:0] speed;
        logic               dir;
        mode_t              mode;
        logic               halted;
    } drive_out_t;

    localparam int PRINT_CAP = 200;

    drive_out_t expected_drive[$];

    // settings
    int unsigned ramp_step_r, pause_r;
    logic [DUTY_W-1:0] floor_r, ceiling_r;

    // motor state
    mode_t       mode_r;
    int unsigned speed_r, target_r, ticks_r;
    logic [31:0] period_r;
    logic        dir_applied, dir_wanted, running_r;
    logic [DUTY_W-1:0] duty_a_r, duty_b_r;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void clear_motor();
        ramp_step_r = RAMP_STEP_RST;
        floor_r     = FLOOR_RST;
        ceiling_r   = CEILING_RST;
        pause_r     = PAUSE_RST;
        mode_r      = MODE_RAMP;
        speed_r     = 0;
        target_r    = 0;
        ticks_r     = 0;
        period_r    = '0;
        dir_applied = 1'b0;
        dir_wanted  = 1'b0;
        running_r   = 1'b0;
        duty_a_r    = '0;
        duty_b_r    = '0;
    endfunction

    function automatic void refresh_duties(logic estop);
        int span;
        int level;
        logic [DUTY_W-1:0] pwm;
        // emergency on a driving tick: kill both outputs and the speed
        if (estop) begin
            duty_a_r = '0;
            duty_b_r = '0;
            speed_r  = 0;
            mode_r   = MODE_RAMP;
            return;
        end
        if (speed_r == 0) begin
            pwm = '0;
        end else if (speed_r >= SPEED_FULL) begin
            pwm = DUTY_FULL;
        end else begin
            span  = int'(ceiling_r) - int'(floor_r);
            level = int'(floor_r) + (int'(speed_r) * span) / int'(SPEED_MAX);
            pwm   = level[DUTY_W-1:0];
        end
        duty_a_r = dir_applied ? pwm : '0;
        duty_b_r = dir_applied ? '0 : pwm;
    endfunction

    function automatic void settle_mode(logic estop);
        if (running_r && !estop) begin
            if (speed_r == 0) begin
                mode_r      = MODE_RAMP;
                dir_applied = dir_wanted;
            end else begin
                mode_r = (dir_wanted == dir_applied) ? MODE_RAMP : MODE_DOWN;
            end
        end else begin
            mode_r = MODE_DOWN;
        end
    endfunction

    function automatic void run_tick(logic estop);
        // the deadline runs down in every mode
        if (ticks_r > 0)
            ticks_r--;
        if (!running_r && speed_r > 0)
            mode_r = MODE_DOWN;
        if (!running_r && speed_r == 0)
            return;
        case (mode_r)
            MODE_RAMP: begin
                if (speed_r == target_r) begin
                    mode_r  = MODE_HOLD;
                    ticks_r = period_r;
                end else begin
                    if (speed_r < target_r) begin
                        speed_r += ramp_step_r;
                        if (speed_r > target_r)
                            speed_r = target_r;
                    end else if (speed_r < target_r + ramp_step_r) begin
                        speed_r = target_r;
                    end else begin
                        speed_r -= ramp_step_r;
                    end
                    refresh_duties(estop);
                end
            end
            MODE_HOLD: begin
                if (period_r != 0 && ticks_r == 0) begin
                    mode_r     = MODE_DOWN;
                    dir_wanted = !dir_wanted;
                end
            end
            MODE_DOWN: begin
                if (speed_r <= ramp_step_r) begin
                    speed_r = 0;
                    ticks_r = pause_r;
                    mode_r  = MODE_PAUSE;
                end else begin
                    speed_r -= ramp_step_r;
                end
                refresh_duties(estop);
            end
            default: begin
                if (ticks_r == 0 && running_r && !estop) begin
                    dir_applied = dir_wanted;
                    mode_r      = MODE_RAMP;
                end
            end
        endcase
    endfunction

    function automatic drive_out_t apply_beat(kind_t kind, logic [S_DATA_W-1:0] beat);
        int          sp;
        logic [31:0] period;
        logic        dir_bit;
        logic        estop;
        drive_out_t  r;
        sp      = $signed(beat[7:0]);
        period  = beat[39:8];
        dir_bit = beat[40];
        estop   = beat[41];
        if (sp < 0)
            sp = 0;
        if (sp > int'(SPEED_MAX))
            sp = int'(SPEED_MAX);
        case (kind)
            KIND_TICK:   run_tick(estop);
            KIND_START:  running_r = 1'b1;
            KIND_STOP:   running_r = 1'b0;
            KIND_DIR:    dir_wanted = dir_bit;
            KIND_TOGGLE: dir_wanted = !dir_wanted;
            KIND_SPEED:  target_r = sp;
            KIND_PERIOD: period_r = period;
            default: begin
                period_r = period;
                target_r = sp;
            end
        endcase
        if (kind != KIND_TICK)
            settle_mode(estop);
        r.duty_a = duty_a_r;
        r.duty_b = duty_b_r;
        r.speed  = speed_r[SPEED_W-1:0];
        r.dir    = dir_applied;
        r.mode   = mode_r;
        r.halted = !running_r || estop;
        return r;
    endfunction

    task automatic check_result(logic [M_DATA_W-1:0] beat);
        drive_out_t want;
        if (expected_drive.size() == 0) begin
            report_mismatch("result beat with nothing expected", beat, 0);
            return;
        end
        want = expected_drive.pop_front();
        if (beat[OUT_A_LSB +: DUTY_W] !== want.duty_a)
            report_mismatch("drive_a", beat[OUT_A_LSB +: DUTY_W], want.duty_a);
        if (beat[OUT_B_LSB +: DUTY_W] !== want.duty_b)
            report_mismatch("drive_b", beat[OUT_B_LSB +: DUTY_W], want.duty_b);
        if (beat[OUT_SPEED_LSB +: SPEED_W] !== want.speed)
            report_mismatch("speed_now", beat[OUT_SPEED_LSB +: SPEED_W], want.speed);
        if (beat[OUT_DIR_LSB] !== want.dir)
            report_mismatch("direction_now", beat[OUT_DIR_LSB], want.dir);
        if (beat[OUT_MODE_LSB +: 2] !== want.mode)
            report_mismatch("mode_now", beat[OUT_MODE_LSB +: 2], want.mode);
        if (beat[OUT_HALT_LSB] !== want.halted)
            report_mismatch("halted", beat[OUT_HALT_LSB], want.halted);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_motor();
            expected_drive.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RAMP_STEP: ramp_step_r = cfg_data[STEP_W-1:0];
                    CFG_FLOOR:     floor_r     = cfg_data[DUTY_W-1:0];
                    CFG_CEILING:   ceiling_r   = cfg_data[DUTY_W-1:0];
                    default:       pause_r     = cfg_data[PAUSE_W-1:0];
                endcase
            end
            // retire the oldest result before queuing the new beat
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                expected_drive.push_back(apply_beat(kind_t'(s_tuser), s_tdata));
        end
        pending = expected_drive.size();
    end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`default_nettype none

module tb_top;
    import mrac_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 3000;
    localparam int PHASES        = 8;
    localparam int BEATS_PER_SET = 250;
    localparam int DRAIN_CYCLES  = 6;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [KIND_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int burst_left = 0;
    int idle_cycles = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_style = 0;
    int style_left = 0;

    // fixed settings for the first random phases: defaults, zero step,
    // full step with inverted duty span, unit step with flat span and longest pause
    logic [STEP_W-1:0]  step_set  [0:3] = '{7'd5, 7'd0, 7'd127, 7'd1};
    logic [DUTY_W-1:0]  floor_set [0:3] = '{8'd0, 8'd0, 8'd255, 8'd128};
    logic [DUTY_W-1:0]  ceil_set  [0:3] = '{8'd255, 8'd255, 8'd0, 8'd128};
    logic [PAUSE_W-1:0] pause_set [0:3] = '{16'd10, 16'd3, 16'd0, 16'hFFFF};

    motor_ramp_autoreverse_controller u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    motor_drive_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    function automatic logic [S_DATA_W-1:0] motor_beat(logic [7:0] speed, logic [31:0] period,
                                                      logic dir_bit, logic estop);
        logic [S_DATA_W-1:0] beat;
        beat        = '0;
        beat[7:0]   = speed;
        beat[39:8]  = period;
        beat[40]    = dir_bit;
        beat[41]    = estop;
        return beat;
    endfunction

    // Offer one beat, with random gaps between bursts; returns on the falling edge
    // after the beat is taken.
    task automatic send_beat(kind_t kind, logic [S_DATA_W-1:0] beat);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= beat;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drain the block, then load all four registers; upper data bits carry noise.
    task automatic write_settings(logic [STEP_W-1:0] step, logic [DUTY_W-1:0] floor_v,
                                  logic [DUTY_W-1:0] ceil_v, logic [PAUSE_W-1:0] pause_v);
        logic [CFG_DATA_W-1:0] junk;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        junk      = CFG_DATA_W'($urandom());
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_RAMP_STEP;
        cfg_data  <= {junk[CFG_DATA_W-1:STEP_W], step};
        @(negedge aclk);
        cfg_index <= CFG_FLOOR;
        cfg_data  <= {junk[CFG_DATA_W-1:DUTY_W], floor_v};
        @(negedge aclk);
        cfg_index <= CFG_CEILING;
        cfg_data  <= {~junk[CFG_DATA_W-1:DUTY_W], ceil_v};
        @(negedge aclk);
        cfg_index <= CFG_PAUSE;
        cfg_data  <= pause_v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // receiver: phases of always-ready, light, heavy and very heavy back-pressure,
    // plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(8, 64);
            end
            style_left--;
            case (stall_style)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        kind_t       kind;
        int          roll;
        logic [7:0]  speed;
        logic [31:0] period;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: clamping, every command, hold expiry, pause, emergency cases
        write_settings(7'd30, 8'd20, 8'd200, 16'd2);
        send_beat(KIND_TICK,   motor_beat(8'd0,   32'd0,         1'b0, 1'b0));
        send_beat(KIND_SPEED,  motor_beat(8'h7F,  32'd0,         1'b0, 1'b0));
        send_beat(KIND_SPEED,  motor_beat(8'h80,  32'hFFFFFFFF,  1'b1, 1'b0));
        send_beat(KIND_BOTH,   motor_beat(8'd70,  32'd2,         1'b0, 1'b0));
        send_beat(KIND_DIR,    motor_beat(8'd0,   32'd0,         1'b1, 1'b0));
        send_beat(KIND_START,  motor_beat(8'd0,   32'd0,         1'b0, 1'b0));
        repeat (4)
            send_beat(KIND_TICK, motor_beat(8'd0, 32'd0,         1'b0, 1'b0));
        repeat (2)
            send_beat(KIND_TICK, motor_beat(8'd0, 32'd0,         1'b0, 1'b0));
        repeat (3)
            send_beat(KIND_TICK, motor_beat(8'd0, 32'd0,         1'b0, 1'b0));
        repeat (2)
            send_beat(KIND_TICK, motor_beat(8'd0, 32'd0,         1'b0, 1'b0));
        send_beat(KIND_TOGGLE, motor_beat(8'd0,   32'd0,         1'b0, 1'b1));
        send_beat(KIND_TICK,   motor_beat(8'd0,   32'd0,         1'b0, 1'b1));
        send_beat(KIND_BOTH,   motor_beat(8'd100, 32'hFFFFFFFF,  1'b1, 1'b0));
        send_beat(KIND_TICK,   motor_beat(8'd0,   32'd0,         1'b0, 1'b0));
        send_beat(KIND_TICK,   motor_beat(8'd0,   32'd0,         1'b0, 1'b1));
        send_beat(KIND_PERIOD, motor_beat(8'd0,   32'd0,         1'b0, 1'b0));
        send_beat(KIND_STOP,   motor_beat(8'd0,   32'd0,         1'b0, 1'b0));
        send_beat(KIND_TICK,   motor_beat(8'd0,   32'd0,         1'b0, 1'b0));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 4)
                write_settings(step_set[phase], floor_set[phase], ceil_set[phase],
                               pause_set[phase]);
            else
                write_settings(STEP_W'($urandom_range(0, 127)),
                               DUTY_W'($urandom_range(0, 255)),
                               DUTY_W'($urandom_range(0, 255)),
                               PAUSE_W'($urandom_range(0, 40)));
            // stall the result side long enough to back up the input
            if (phase == 1)
                hold_req = 1'b1;
            for (int n = 0; n < BEATS_PER_SET; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 55)      kind = KIND_TICK;
                else if (roll < 63) kind = KIND_START;
                else if (roll < 67) kind = KIND_STOP;
                else if (roll < 72) kind = KIND_DIR;
                else if (roll < 77) kind = KIND_TOGGLE;
                else if (roll < 87) kind = KIND_SPEED;
                else if (roll < 93) kind = KIND_PERIOD;
                else                kind = KIND_BOTH;
                speed = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 100));
                case ($urandom_range(0, 7))
                    0:       period = '0;
                    1:       period = $urandom();
                    default: period = $urandom_range(1, 25);
                endcase
                send_beat(kind, motor_beat(speed, period, 1'($urandom_range(0, 1)),
                                           ($urandom_range(0, 29) == 0)));
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+src
src/mrac_pkg.sv
src/motor_ramp_autoreverse_controller.sv
src/mrac_checker.sv
dv/motor_drive_checker.sv
dv/tb_top.sv
